FILE: hdl/sabe_pkg.sv
// Package for the scaled alpha blit engine: command and status codes, the
// control and status bundles between controller and datapath, and pixel helpers.
// No dependencies.
package sabe_pkg;

  localparam logic [1:0] CmdLoad  = 2'd0;
  localparam logic [1:0] CmdWrite = 2'd1;
  localparam logic [1:0] CmdRead  = 2'd2;
  localparam logic [1:0] CmdBlit  = 2'd3;

  localparam logic [1:0] StsDone   = 2'd0;
  localparam logic [1:0] StsMemOob = 2'd1;
  localparam logic [1:0] StsWinOut = 2'd2;
  localparam logic [1:0] StsSrcOut = 2'd3;

  localparam logic [2:0] RegSrcOrigin  = 3'd0;
  localparam logic [2:0] RegSrcExtent  = 3'd1;
  localparam logic [2:0] RegDstOrigin  = 3'd2;
  localparam logic [2:0] RegDstExtent  = 3'd3;
  localparam logic [2:0] RegTint       = 3'd4;
  localparam logic [2:0] RegSurfAlpha  = 3'd5;
  localparam logic [2:0] RegFlip       = 3'd6;

  localparam logic [1:0] ResZero  = 2'd0;
  localparam logic [1:0] ResPix   = 2'd1;
  localparam logic [1:0] ResRead  = 2'd2;
  localparam logic [1:0] ResBlend = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch;
    logic       prod_en;
    logic       prod_sel_x;
    logic       div_start;
    logic       qy_en;
    logic       qx_en;
    logic       mem_rd;
    logic       tint_en;
    logic       blend_en;
    logic       src_wr;
    logic       tgt_wr;
    logic       tgt_sel_blend;
    logic       res_en;
    logic [1:0] res_status;
    logic [1:0] res_sel;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] cmd;
    logic       oob_src;
    logic       oob_tgt;
    logic       src_zero;
    logic       win_out;
    logic       map_out;
    logic       div_busy;
  } dp_sts_t;

  // Exact floor(t / 255) for any t below 65280, by reciprocal multiplication.
  function automatic logic [7:0] div255(input logic [15:0] t);
    logic [31:0] p;
    p = 32'(t) * 32'd32897;
    return p[30:23];
  endfunction

  // Product of two 8-bit fractions with rounding.
  function automatic logic [7:0] mul8(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] p;
    p = 16'(a) * 16'(b) + 16'd127;
    return div255(p);
  endfunction

endpackage

FILE: hdl/sabe_divider.sv
// Radix-2 restoring divider, 32-bit dividend by 16-bit divisor, one bit a cycle.
// Depends on nothing.
module sabe_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        busy_o,
  output logic [15:0] quotient_o
);

  logic [31:0] dvd_q, dvd_d;
  logic [15:0] rem_q, rem_d, dsr_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic [16:0] trial;

  // One shift and trial subtraction per cycle.
  always_comb begin
    trial = {rem_q, dvd_q[31]};
    if (trial >= {1'b0, dsr_q}) begin
      rem_d = 16'(trial - {1'b0, dsr_q});
      dvd_d = {dvd_q[30:0], 1'b1};
    end else begin
      rem_d = trial[15:0];
      dvd_d = {dvd_q[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = dvd_q[15:0];

endmodule

FILE: hdl/sabe_datapath.sv
// Datapath of the blit engine: configuration registers, both pixel memories,
// coordinate checks, scaling multiplier and divider, tint and blend arithmetic.
// Depends on sabe_pkg and sabe_divider.
module sabe_datapath #(
  parameter int SOURCE_WIDTH  = 64,
  parameter int SOURCE_HEIGHT = 64,
  parameter int TARGET_WIDTH  = 128,
  parameter int TARGET_HEIGHT = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [2:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i,
  input  logic [1:0]       cmd_i,
  input  logic [15:0]      pos_x_i,
  input  logic [15:0]      pos_y_i,
  input  logic [31:0]      pixel_value_i,
  input  sabe_pkg::dp_cmd_t ctl_i,
  output sabe_pkg::dp_sts_t sts_o,
  output logic             result_valid_o,
  output logic [31:0]      pixel_out_o,
  output logic [1:0]       status_o
);
  import sabe_pkg::*;

  localparam int SrcDepth = SOURCE_WIDTH * SOURCE_HEIGHT;
  localparam int TgtDepth = TARGET_WIDTH * TARGET_HEIGHT;
  localparam int SrcAw = (SrcDepth > 1) ? $clog2(SrcDepth) : 1;
  localparam int TgtAw = (TgtDepth > 1) ? $clog2(TgtDepth) : 1;
  localparam logic [16:0] SrcW = 17'(SOURCE_WIDTH);
  localparam logic [16:0] SrcH = 17'(SOURCE_HEIGHT);
  localparam logic [16:0] TgtW = 17'(TARGET_WIDTH);
  localparam logic [16:0] TgtH = 17'(TARGET_HEIGHT);

  logic [31:0] src_org_q, src_ext_q, dst_org_q, dst_ext_q;
  logic [23:0] tint_q;
  logic [7:0]  salpha_q;
  logic        flip_q;

  logic [1:0]  cmd_q;
  logic [15:0] x_q, y_q;
  logic [31:0] pix_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_org_q <= '0;
      src_ext_q <= '0;
      dst_org_q <= '0;
      dst_ext_q <= '0;
      tint_q    <= 24'hFFFFFF;
      salpha_q  <= 8'hFF;
      flip_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegSrcOrigin: src_org_q <= cfg_data_i;
        RegSrcExtent: src_ext_q <= cfg_data_i;
        RegDstOrigin: dst_org_q <= cfg_data_i;
        RegDstExtent: dst_ext_q <= cfg_data_i;
        RegTint:      tint_q    <= cfg_data_i[23:0];
        RegSurfAlpha: salpha_q  <= cfg_data_i[7:0];
        RegFlip:      flip_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Command capture.
  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      cmd_q <= cmd_i;
      x_q   <= pos_x_i;
      y_q   <= pos_y_i;
      pix_q <= pixel_value_i;
    end
  end

  // Memory bounds: a negative coordinate has its sign bit set.
  logic oob_src, oob_tgt;
  assign oob_src = x_q[15] | y_q[15] | ({2'b0, x_q[14:0]} >= SrcW) |
                   ({2'b0, y_q[14:0]} >= SrcH);
  assign oob_tgt = x_q[15] | y_q[15] | ({2'b0, x_q[14:0]} >= TgtW) |
                   ({2'b0, y_q[14:0]} >= TgtH);

  // Destination window check on 17-bit offsets.
  logic [15:0] sw, sh, dw, dh;
  logic [16:0] dx_off, dy_off;
  logic        win_out;
  assign sw = src_ext_q[15:0];
  assign sh = src_ext_q[31:16];
  assign dw = dst_ext_q[15:0];
  assign dh = dst_ext_q[31:16];
  assign dx_off = {x_q[15], x_q} - {dst_org_q[15], dst_org_q[15:0]};
  assign dy_off = {y_q[15], y_q} - {dst_org_q[31], dst_org_q[31:16]};
  assign win_out = (dw == '0) | (dh == '0) | dx_off[16] | dy_off[16] |
                   (dx_off[15:0] >= dw) | (dy_off[15:0] >= dh);

  // Scaling product, one multiplier shared by both axes.
  logic [31:0] prod_q;
  logic        axis_x_q;
  always_ff @(posedge clk_i) begin
    if (ctl_i.prod_en) begin
      prod_q   <= ctl_i.prod_sel_x ? 32'(dx_off[15:0]) * 32'(sw)
                                   : 32'(dy_off[15:0]) * 32'(sh);
      axis_x_q <= ctl_i.prod_sel_x;
    end
  end

  logic        div_busy;
  logic [15:0] quot;
  sabe_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl_i.div_start),
    .dividend_i (prod_q),
    .divisor_i  (axis_x_q ? dw : dh),
    .busy_o     (div_busy),
    .quotient_o (quot)
  );

  logic [15:0] qy_q, qx_q;
  always_ff @(posedge clk_i) begin
    if (ctl_i.qy_en) qy_q <= quot;
    if (ctl_i.qx_en) qx_q <= quot;
  end

  // Source mapping; the quotient is below the source extent.
  logic [15:0] lx;
  logic [17:0] sx, sy;
  logic        map_out;
  assign lx = flip_q ? 16'(sw - 16'd1 - qx_q) : qx_q;
  assign sx = {{2{src_org_q[15]}}, src_org_q[15:0]} + {2'b0, lx};
  assign sy = {{2{src_org_q[31]}}, src_org_q[31:16]} + {2'b0, qy_q};
  assign map_out = sy[17] | sx[17] | (sy[16:0] >= SrcH) | (sx[16:0] >= SrcW);

  // Addresses; all three are only used once the coordinates are in range.
  logic [SrcAw-1:0] src_addr_ld, src_addr_map;
  logic [TgtAw-1:0] tgt_addr;
  assign src_addr_ld  = SrcAw'(SrcAw'(y_q[11:0]) * SrcAw'(SOURCE_WIDTH)) +
                        SrcAw'(x_q[11:0]);
  assign src_addr_map = SrcAw'(SrcAw'(sy[11:0]) * SrcAw'(SOURCE_WIDTH)) +
                        SrcAw'(sx[11:0]);
  assign tgt_addr     = TgtAw'(TgtAw'(y_q[11:0]) * TgtAw'(TARGET_WIDTH)) +
                        TgtAw'(x_q[11:0]);

  // Pixel memories with registered reads.
  logic [31:0] src_mem [SrcDepth];
  logic [31:0] tgt_mem [TgtDepth];
  logic [31:0] src_rd_q, tgt_rd_q, blend_pix;

  always_ff @(posedge clk_i) begin
    if (ctl_i.src_wr) src_mem[src_addr_ld] <= pix_q;
    if (ctl_i.mem_rd) src_rd_q <= src_mem[src_addr_map];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.tgt_wr) tgt_mem[tgt_addr] <= ctl_i.tgt_sel_blend ? blend_pix : pix_q;
    if (ctl_i.mem_rd) tgt_rd_q <= tgt_mem[tgt_addr];
  end

  // Tint and alpha scaling of the source pixel.
  logic [7:0] sr_q, sg_q, sb_q, sa_q;
  always_ff @(posedge clk_i) begin
    if (ctl_i.tint_en) begin
      sr_q <= mul8(src_rd_q[7:0], tint_q[7:0]);
      sg_q <= mul8(src_rd_q[15:8], tint_q[15:8]);
      sb_q <= mul8(src_rd_q[23:16], tint_q[23:16]);
      sa_q <= mul8(src_rd_q[31:24], salpha_q);
    end
  end

  // Weighted sums of source and target; alpha 0 and 255 fall out exactly.
  logic [7:0]  inv;
  logic [15:0] pr_q, pg_q, pb_q, pa_q;
  assign inv = 8'd255 - sa_q;
  always_ff @(posedge clk_i) begin
    if (ctl_i.blend_en) begin
      pr_q <= 16'(sr_q) * 16'(sa_q) + 16'(tgt_rd_q[7:0]) * 16'(inv) + 16'd127;
      pg_q <= 16'(sg_q) * 16'(sa_q) + 16'(tgt_rd_q[15:8]) * 16'(inv) + 16'd127;
      pb_q <= 16'(sb_q) * 16'(sa_q) + 16'(tgt_rd_q[23:16]) * 16'(inv) + 16'd127;
      pa_q <= 16'(tgt_rd_q[31:24]) * 16'(inv) + 16'd127;
    end
  end
  assign blend_pix = {8'(sa_q + div255(pa_q)), div255(pb_q), div255(pg_q), div255(pr_q)};

  // Result register.
  logic        res_valid_q;
  logic [31:0] res_pix_q;
  logic [1:0]  res_sts_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= ctl_i.res_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.res_en) begin
      res_sts_q <= ctl_i.res_status;
      case (ctl_i.res_sel)
        ResPix:   res_pix_q <= pix_q;
        ResRead:  res_pix_q <= tgt_rd_q;
        ResBlend: res_pix_q <= blend_pix;
        default:  res_pix_q <= '0;
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign pixel_out_o    = res_pix_q;
  assign status_o       = res_sts_q;

  assign sts_o.cmd      = cmd_q;
  assign sts_o.oob_src  = oob_src;
  assign sts_o.oob_tgt  = oob_tgt;
  assign sts_o.src_zero = (sw == '0) | (sh == '0);
  assign sts_o.win_out  = win_out;
  assign sts_o.map_out  = map_out;
  assign sts_o.div_busy = div_busy;

endmodule

FILE: hdl/sabe_ctrl.sv
// Controller state machine of the blit engine, sequencing the datapath.
// Depends on sabe_pkg.
module sabe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  sabe_pkg::dp_sts_t sts_i,
  output sabe_pkg::dp_cmd_t ctl_o
);
  import sabe_pkg::*;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StCheck = 4'd1;
  localparam logic [3:0] StRdW   = 4'd2;
  localparam logic [3:0] StDivY  = 4'd3;
  localparam logic [3:0] StWaitY = 4'd4;
  localparam logic [3:0] StDivX  = 4'd5;
  localparam logic [3:0] StWaitX = 4'd6;
  localparam logic [3:0] StMap   = 4'd7;
  localparam logic [3:0] StTint  = 4'd8;
  localparam logic [3:0] StBlend = 4'd9;
  localparam logic [3:0] StWrite = 4'd10;

  logic [3:0] state_q, state_d;

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          ctl_o.latch = 1'b1;
          state_d     = StCheck;
        end
      end
      StCheck: begin
        state_d = StIdle;
        ctl_o.res_en = 1'b1;
        case (sts_i.cmd)
          CmdLoad: begin
            if (sts_i.oob_src) begin
              ctl_o.res_status = StsMemOob;
            end else begin
              ctl_o.src_wr  = 1'b1;
              ctl_o.res_sel = ResPix;
            end
          end
          CmdWrite: begin
            if (sts_i.oob_tgt) begin
              ctl_o.res_status = StsMemOob;
            end else begin
              ctl_o.tgt_wr  = 1'b1;
              ctl_o.res_sel = ResPix;
            end
          end
          CmdRead: begin
            if (sts_i.oob_tgt) begin
              ctl_o.res_status = StsMemOob;
            end else begin
              ctl_o.res_en = 1'b0;
              ctl_o.mem_rd = 1'b1;
              state_d      = StRdW;
            end
          end
          default: begin
            if (sts_i.oob_tgt) begin
              ctl_o.res_status = StsMemOob;
            end else if (sts_i.src_zero) begin
              ctl_o.res_status = StsSrcOut;
            end else if (sts_i.win_out) begin
              ctl_o.res_status = StsWinOut;
            end else begin
              ctl_o.res_en  = 1'b0;
              ctl_o.prod_en = 1'b1;
              state_d       = StDivY;
            end
          end
        endcase
      end
      StRdW: begin
        ctl_o.res_en  = 1'b1;
        ctl_o.res_sel = ResRead;
        state_d       = StIdle;
      end
      StDivY: begin
        ctl_o.div_start = 1'b1;
        state_d         = StWaitY;
      end
      StWaitY: begin
        if (!sts_i.div_busy) begin
          ctl_o.qy_en      = 1'b1;
          ctl_o.prod_en    = 1'b1;
          ctl_o.prod_sel_x = 1'b1;
          state_d          = StDivX;
        end
      end
      StDivX: begin
        ctl_o.div_start = 1'b1;
        state_d         = StWaitX;
      end
      StWaitX: begin
        if (!sts_i.div_busy) begin
          ctl_o.qx_en = 1'b1;
          state_d     = StMap;
        end
      end
      StMap: begin
        if (sts_i.map_out) begin
          ctl_o.res_en     = 1'b1;
          ctl_o.res_status = StsSrcOut;
          state_d          = StIdle;
        end else begin
          ctl_o.mem_rd = 1'b1;
          state_d      = StTint;
        end
      end
      StTint: begin
        ctl_o.tint_en = 1'b1;
        state_d       = StBlend;
      end
      StBlend: begin
        ctl_o.blend_en = 1'b1;
        state_d        = StWrite;
      end
      StWrite: begin
        ctl_o.tgt_wr        = 1'b1;
        ctl_o.tgt_sel_blend = 1'b1;
        ctl_o.res_en        = 1'b1;
        ctl_o.res_sel       = ResBlend;
        state_d             = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);

`ifndef ASSERT_OFF
  // A result always ends the command.
  a_res_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.res_en |=> state_q == StIdle) else $error("result without return to idle");
  // An accepted command is checked on the next cycle.
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> state_q == StCheck) else $error("accept not followed by check");
  // The divider takes every start.
  a_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.div_start |=> sts_i.div_busy) else $error("divider did not start");
  // A failed status carries no pixel.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.res_en && ctl_o.res_status != StsDone |-> ctl_o.res_sel == ResZero)
    else $error("pixel on failed status");
`endif

endmodule

FILE: hdl/scaled_alpha_blit_engine.sv
// Top level of the scaled alpha blit engine.
// Depends on sabe_pkg, sabe_ctrl and sabe_datapath.
//
// One command is taken when start_i is high and busy_o is low; busy_o stays
// high until its result has been registered. Load and write are checked and
// answered in the check state; read passes through a read wait state. A blit
// step that reaches the blend runs two 32-step divisions one after the other on
// the single radix-2 divider; a step whose mapped source falls outside the
// source surface ends at the mapping check, and steps rejected by the target,
// extent or window checks end in the check state. The next command can be
// taken at the edge that ends the result strobe. The result is shown
// for one cycle on result_valid_o and the receiver cannot stall it.
// Configuration writes are always ready and must only be made while busy_o is
// low. Memories have no reset contents.
module scaled_alpha_blit_engine #(
  parameter int SOURCE_WIDTH  = 64,
  parameter int SOURCE_HEIGHT = 64,
  parameter int TARGET_WIDTH  = 128,
  parameter int TARGET_HEIGHT = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic [31:0]        pixel_value_i,
  output logic               result_valid_o,
  output logic [31:0]        pixel_out_o,
  output logic [1:0]         status_o
);
  import sabe_pkg::*;

  dp_cmd_t ctl;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  // Sequencing.
  sabe_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .sts_i   (sts),
    .ctl_o   (ctl)
  );

  // Storage and arithmetic.
  sabe_datapath #(
    .SOURCE_WIDTH  (SOURCE_WIDTH),
    .SOURCE_HEIGHT (SOURCE_HEIGHT),
    .TARGET_WIDTH  (TARGET_WIDTH),
    .TARGET_HEIGHT (TARGET_HEIGHT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pixel_value_i  (pixel_value_i),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .pixel_out_o    (pixel_out_o),
    .status_o       (status_o)
  );

endmodule

FILE: tb/sv/scaled_alpha_blit_engine_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the scaled alpha blit engine: directed and random
// commands under several register settings, predicted by an in-bench pixel model.
// Depends on sabe_pkg and scaled_alpha_blit_engine.
module scaled_alpha_blit_engine_tb;
  import sabe_pkg::*;

  localparam int SrcW = 64;
  localparam int SrcH = 64;
  localparam int TgtW = 128;
  localparam int TgtH = 128;

  typedef struct {
    logic [31:0] pix;
    logic [1:0]  sts;
  } pixel_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [1:0]         cmd_i = '0;
  logic signed [15:0] pos_x_i = '0;
  logic signed [15:0] pos_y_i = '0;
  logic [31:0]        pixel_value_i = '0;
  logic               result_valid_o;
  logic [31:0]        pixel_out_o;
  logic [1:0]         status_o;

  // Shadow copy of the surfaces and registers.
  logic [31:0] src_pix [SrcW*SrcH];
  bit          src_set [SrcW*SrcH];
  logic [31:0] tgt_pix [TgtW*TgtH];
  bit          tgt_set [TgtW*TgtH];
  logic [31:0] src_org = '0, src_ext = '0, dst_org = '0, dst_ext = '0;
  logic [23:0] tint = 24'hFFFFFF;
  logic [7:0]  surf_alpha = 8'hFF;
  logic        mirror = 1'b0;

  pixel_result_t pending_results [$];
  int errors = 0;
  int commands_sent = 0;
  int results_seen = 0;
  int blends_done = 0;
  int idle_pct = 0;

  scaled_alpha_blit_engine dut (.*);

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    errors++;
    $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
  endtask

  // Every strobed result is matched against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", '0, pixel_out_o);
      end else begin
        pixel_result_t e;
        e = pending_results.pop_front();
        if (status_o !== e.sts) report_mismatch("status", e.sts, status_o);
        if (pixel_out_o !== e.pix) report_mismatch("pixel", e.pix, pixel_out_o);
      end
    end
  end

  function automatic longint sx16(input logic [15:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic int frac_mul(input int a, input int b);
    return (a * b + 127) / 255;
  endfunction

  // Tint and fade the source, then composite it over the target pixel.
  function automatic logic [31:0] composite(input logic [31:0] dst, input logic [31:0] src);
    int sr, sg, sb, sa, inv, r, g, b, a;
    sr = frac_mul(src[7:0], tint[7:0]);
    sg = frac_mul(src[15:8], tint[15:8]);
    sb = frac_mul(src[23:16], tint[23:16]);
    sa = frac_mul(src[31:24], surf_alpha);
    if (sa == 0) return dst;
    if (sa == 255) return {8'hFF, 8'(sb), 8'(sg), 8'(sr)};
    inv = 255 - sa;
    r = (sr * sa + dst[7:0] * inv + 127) / 255;
    g = (sg * sa + dst[15:8] * inv + 127) / 255;
    b = (sb * sa + dst[23:16] * inv + 127) / 255;
    a = sa + (dst[31:24] * inv + 127) / 255;
    return {8'(a), 8'(b), 8'(g), 8'(r)};
  endfunction

  function automatic bit in_target(input longint x, input longint y);
    return x >= 0 && y >= 0 && x < TgtW && y < TgtH;
  endfunction

  // Window and scaling checks of a blit step whose destination lies in the target.
  function automatic logic [1:0] map_source(input longint x, input longint y,
                                            output int src_idx);
    longint sw, sh, dw, dh, dxo, dyo, sy, lx, sxp;
    sw = src_ext[15:0]; sh = src_ext[31:16];
    dw = dst_ext[15:0]; dh = dst_ext[31:16];
    dxo = sx16(dst_org[15:0]); dyo = sx16(dst_org[31:16]);
    src_idx = 0;
    if (sw == 0 || sh == 0) return StsSrcOut;
    if (dw == 0 || dh == 0 || x < dxo || y < dyo || x >= dxo + dw || y >= dyo + dh)
      return StsWinOut;
    sy = sx16(src_org[31:16]) + ((y - dyo) * sh) / dh;
    lx = ((x - dxo) * sw) / dw;
    if (mirror) lx = sw - 1 - lx;
    sxp = sx16(src_org[15:0]) + lx;
    if (sy < 0 || sy >= SrcH || sxp < 0 || sxp >= SrcW) return StsSrcOut;
    src_idx = int'(sy * SrcW + sxp);
    return StsDone;
  endfunction

  function automatic pixel_result_t execute(input logic [1:0] cmd, input logic [15:0] px,
                                            input logic [15:0] py, input logic [31:0] pix);
    pixel_result_t r;
    longint x, y;
    int ti, si;
    x = sx16(px); y = sx16(py);
    r.pix = '0; r.sts = StsDone;
    ti = int'(y * TgtW + x);
    if (cmd == CmdLoad) begin
      if (x < 0 || y < 0 || x >= SrcW || y >= SrcH) begin
        r.sts = StsMemOob;
      end else begin
        src_pix[y*SrcW+x] = pix; src_set[y*SrcW+x] = 1'b1; r.pix = pix;
      end
    end else if (!in_target(x, y)) begin
      r.sts = StsMemOob;
    end else if (cmd == CmdWrite) begin
      tgt_pix[ti] = pix; tgt_set[ti] = 1'b1; r.pix = pix;
    end else if (cmd == CmdRead) begin
      r.pix = tgt_pix[ti];
    end else begin
      r.sts = map_source(x, y, si);
      if (r.sts == StsDone) begin
        tgt_pix[ti] = composite(tgt_pix[ti], src_pix[si]);
        r.pix = tgt_pix[ti];
        blends_done++;
      end
    end
    return r;
  endfunction

  // One command transfer; the start line is only lowered when an idle gap follows.
  task automatic send_command(input logic [1:0] cmd, input logic [15:0] px,
                              input logic [15:0] py, input logic [31:0] pix);
    start_i <= 1'b1;
    cmd_i <= cmd; pos_x_i <= px; pos_y_i <= py; pixel_value_i <= pix;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(execute(cmd, px, py, pix));
    commands_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] random_pixel();
    logic [31:0] p;
    p = $urandom;
    case ($urandom_range(3))
      0: p[31:24] = 8'h00;
      1: p[31:24] = 8'hFF;
      default: ;
    endcase
    return p;
  endfunction

  // Blit step; any memory entry it would read is written beforehand.
  task automatic blit_at(input logic [15:0] px, input logic [15:0] py);
    int si, ti;
    longint x, y;
    x = sx16(px); y = sx16(py);
    if (in_target(x, y) && map_source(x, y, si) == StsDone) begin
      ti = int'(y * TgtW + x);
      if (!src_set[si]) send_command(CmdLoad, 16'(si % SrcW), 16'(si / SrcW), random_pixel());
      if (!tgt_set[ti]) send_command(CmdWrite, px, py, random_pixel());
    end
    send_command(CmdBlit, px, py, '0);
  endtask

  task automatic read_at(input logic [15:0] px, input logic [15:0] py);
    longint x, y;
    x = sx16(px); y = sx16(py);
    if (in_target(x, y) && !tgt_set[y*TgtW+x])
      send_command(CmdWrite, px, py, random_pixel());
    send_command(CmdRead, px, py, '0);
  endtask

  // Lets every outstanding command finish before registers change.
  task automatic wait_idle();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    do @(posedge clk_i); while (busy_o);
  endtask

  // One register transfer, after which the write channel is left quiet before the task returns.
  task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegSrcOrigin: src_org = data;
      RegSrcExtent: src_ext = data;
      RegDstOrigin: dst_org = data;
      RegDstExtent: dst_ext = data;
      RegTint:      tint = data[23:0];
      RegSurfAlpha: surf_alpha = data[7:0];
      RegFlip:      mirror = data[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_window(input logic [31:0] so, input logic [31:0] se,
                            input logic [31:0] dorg, input logic [31:0] de);
    write_register(RegSrcOrigin, so);
    write_register(RegSrcExtent, se);
    write_register(RegDstOrigin, dorg);
    write_register(RegDstExtent, de);
  endtask

  // Field extremes, every command and each rejection reason of a blit step.
  task automatic test_directed();
    send_command(CmdLoad, 16'sh8000, 16'sh8000, 32'hFFFF_FFFF);
    send_command(CmdLoad, 16'sh7FFF, 16'sh7FFF, 32'h0);
    send_command(CmdLoad, 16'd63, 16'd63, 32'hFFFF_FFFF);
    send_command(CmdLoad, 16'd0, 16'd0, 32'h8040_20FF);
    send_command(CmdWrite, 16'd127, 16'd127, 32'h0);
    send_command(CmdWrite, 16'd128, 16'd0, 32'h1234_5678);
    send_command(CmdWrite, 16'hFFFF, 16'd5, 32'h1234_5678);
    read_at(16'd127, 16'd127);
    read_at(16'd0, 16'd128);
    blit_at(16'd3, 16'd3);
    blit_at(16'sh8000, 16'd3);
    wait_idle();
    set_window({16'd0, 16'd0}, {16'd8, 16'd8}, {16'd20, 16'd10}, {16'd4, 16'd0});
    blit_at(16'd20, 16'd10);
    wait_idle();
    write_register(RegDstExtent, {16'd8, 16'd16});
    blit_at(16'd19, 16'd10);
    blit_at(16'd36, 16'd18);
    blit_at(16'd20, 16'd10);
    blit_at(16'd35, 16'd17);
    wait_idle();
    write_register(RegFlip, 32'd1);
    write_register(RegSurfAlpha, 32'd0);
    blit_at(16'd21, 16'd11);
    wait_idle();
    write_register(RegSurfAlpha, 32'd255);
    write_register(RegTint, 32'h0080_40FF);
    blit_at(16'd22, 16'd12);
    blit_at(16'd23, 16'd13);
    wait_idle();
    write_register(RegSrcOrigin, {16'd60, 16'd62});
    blit_at(16'd35, 16'd17);
    blit_at(16'd20, 16'd10);
    wait_idle();
  endtask

  // Window-heavy random traffic under one register setting.
  task automatic test_random_phase(input int phase, input int count);
    int dxo, dyo, dw, dh, x, y, pick;
    idle_pct = (phase % 4 == 0) ? 0 : (phase % 4 == 3) ? 34 : 50;
    set_window({16'($urandom_range(0, 72) - 8), 16'($urandom_range(0, 72) - 8)},
               {16'($urandom_range(1, 40)), 16'($urandom_range(1, 40))},
               {16'($urandom_range(0, 124) - 4), 16'($urandom_range(0, 124) - 4)},
               {16'($urandom_range(1, 48)), 16'($urandom_range(1, 48))});
    write_register(RegTint, $urandom);
    write_register(RegSurfAlpha, $urandom);
    write_register(RegFlip, $urandom);
    case (phase)
      1: write_register(RegSurfAlpha, 32'h0);
      2: begin write_register(RegSurfAlpha, 32'hFF); write_register(RegTint, 32'h0); end
      3: begin
        set_window(32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        write_register(RegTint, 32'hFFFF_FFFF);
      end
      4: write_register(RegSrcOrigin, 32'h8000_8000);
      5: write_register(RegSrcOrigin, 32'h7FFF_7FFF);
      default: ;
    endcase
    dxo = int'(sx16(dst_org[15:0])); dyo = int'(sx16(dst_org[31:16]));
    dw = (dst_ext[15:0] > 48) ? 48 : dst_ext[15:0];
    dh = (dst_ext[31:16] > 48) ? 48 : dst_ext[31:16];
    for (int i = 0; i < count; i++) begin
      x = dxo + $urandom_range(0, dw + 1) - 1;
      y = dyo + $urandom_range(0, dh + 1) - 1;
      if ($urandom_range(9) == 0) begin
        x = $signed(16'($urandom)); y = $signed(16'($urandom));
      end
      pick = $urandom_range(99);
      if (pick < 15) send_command(CmdLoad, 16'($urandom_range(0, 65) - 1),
                                  16'($urandom_range(0, 65) - 1), random_pixel());
      else if (pick < 35) send_command(CmdWrite, 16'(x), 16'(y), random_pixel());
      else if (pick < 50) read_at(16'(x), 16'(y));
      else blit_at(16'(x), 16'(y));
    end
    wait_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    for (int p = 0; p < 8; p++) test_random_phase(p, 100);
    repeat (100) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0d predicted results never arrived", pending_results.size());
    end
    $display("covered %0d commands, %0d results, %0d blended pixels over 8 settings",
             commands_sent, results_seen, blends_done);
    if (errors == 0) begin
      $display("scaled_alpha_blit_engine_tb: clean");
    end else begin
      $display("scaled_alpha_blit_engine_tb: errors");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #20ms;
    $display("scaled_alpha_blit_engine_tb: errors");
    $finish;
  end

endmodule
